[rtl/olst_pkg.sv]
// Package for the ordered list engine: sizing constants, command and status
// codes, and the packed command and result beat types. No dependencies.
`default_nettype none

package olst_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	// Field widths fixed by the interface.
	localparam int CMD_W      = 3;
	localparam int ITEM_W     = 32;
	localparam int POS_W      = 4;
	localparam int STATUS_W   = 2;
	localparam int ECOUNT_W   = 5;

	// Internal widths derived from the capacity.
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_READ     = 3'd2,
		CMD_CONTAINS = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [ITEM_W-1:0] item_value;
		logic [POS_W-1:0]  position;
	} cmd_beat_t;

	typedef struct packed {
		status_t             status;
		logic [ITEM_W-1:0]   read_value;
		logic [ECOUNT_W-1:0] entry_count;
	} rsp_beat_t;

endpackage

`default_nettype wire

[rtl/olst_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[rtl/ordered_list_engine.sv]
// Ordered list engine top level: command sequencer, entry count and result
// register around one entry RAM. Depends on olst_pkg and olst_ram.
`default_nettype none

//  channel   | ports                 | handshake
//  ----------+-----------------------+-----------------------------------------
//  command   | start, busy, item     | beat taken when start high, busy low
//  result    | done, result          | one-cycle strobe, no back-pressure
//
// Steps: append, clear and unused codes finish in the execute state, a read
// by position then passes through a RAM read state, contains and remove scan
// with one RAM read per entry, and remove then does one read/write per entry shifted down.
// The single RAM read port and the shared equality comparator set the rate.
// Reset clears the count and the sequencer; entry storage is not cleared.
// busy is high from the cycle after accept until the result strobe; the
// result strobe never waits on the receiver.

module ordered_list_engine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire olst_pkg::cmd_beat_t item,
	output logic                     done,
	output olst_pkg::rsp_beat_t      result
);

	import olst_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_READ
	} state_t;

	state_t                state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  done_q;
	rsp_beat_t             rsp_q;

	// RAM port signals
	logic                  ram_we;
	logic [IDX_W-1:0]      ram_waddr;
	logic [VALUE_BITS-1:0] ram_wdata;
	logic [IDX_W-1:0]      ram_raddr;
	logic [VALUE_BITS-1:0] ram_rdata;

	// shared decision terms
	logic             full;
	logic             empty;
	logic             pos_ok;
	logic             hit;
	logic             last;
	logic [CNT_W-1:0] nxt;

	assign full   = (count_q >= CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign pos_ok = (CMP_W'(pos_q) < CMP_W'(count_q));
	assign nxt    = CNT_W'(idx_q) + CNT_W'(1);
	// the entry whose data arrives now is the last valid one
	assign last   = (nxt >= count_q);
	// one equality comparator serves every scan step
	assign hit    = (ram_rdata == val_q);

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	// Drive the RAM: append writes at the tail, shift copies an entry down,
	// scan and shift fetch the next entry, execute the read position or first entry.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(count_q);
		ram_wdata = val_q;
		ram_raddr = nxt[IDX_W-1:0];
		unique case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_APPEND && !full) begin
					ram_we = 1'b1;
				end
				if (cmd_q == CMD_READ) begin
					ram_raddr = IDX_W'(pos_q);
				end else begin
					ram_raddr = '0;
				end
			end
			S_SHIFT: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q - IDX_W'(1);
				ram_wdata = ram_rdata;
			end
			S_IDLE, S_SCAN, S_READ: begin
			end
			default: begin
			end
		endcase
	end

	olst_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
			idx_q   <= '0;
			cmd_q   <= '0;
			val_q   <= '0;
			pos_q   <= '0;
			rsp_q   <= '0;
		end else begin
			// the strobe lasts one cycle
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						// capture the command beat
						cmd_q   <= item.cmd;
						val_q   <= VALUE_BITS'(item.item_value);
						pos_q   <= item.position;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					// default result: done, no read data
					rsp_q.status     <= ST_OK;
					rsp_q.read_value <= '0;
					if (cmd_q == CMD_APPEND) begin
						if (full) begin
							rsp_q.status      <= ST_FULL;
							rsp_q.entry_count <= ECOUNT_W'(count_q);
						end else begin
							count_q           <= count_q + CNT_W'(1);
							rsp_q.entry_count <= ECOUNT_W'(count_q + CNT_W'(1));
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (cmd_q == CMD_REMOVE || cmd_q == CMD_CONTAINS) begin
						rsp_q.entry_count <= ECOUNT_W'(count_q);
						if (empty) begin
							rsp_q.status <= ST_MISSING;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end else begin
							// first entry is being fetched
							idx_q   <= '0;
							state_q <= S_SCAN;
						end
					end else if (cmd_q == CMD_READ) begin
						rsp_q.entry_count <= ECOUNT_W'(count_q);
						if (pos_ok) begin
							state_q <= S_READ;
						end else begin
							rsp_q.status <= ST_MISSING;
							done_q       <= 1'b1;
							state_q      <= S_IDLE;
						end
					end else if (cmd_q == CMD_CLEAR) begin
						count_q           <= '0;
						rsp_q.entry_count <= '0;
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						// unused code: report done, list unchanged
						rsp_q.entry_count <= ECOUNT_W'(count_q);
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (cmd_q == CMD_REMOVE && !last) begin
							// start compacting from the entry after the match
							idx_q   <= nxt[IDX_W-1:0];
							state_q <= S_SHIFT;
						end else begin
							if (cmd_q == CMD_REMOVE) begin
								count_q           <= count_q - CNT_W'(1);
								rsp_q.entry_count <= ECOUNT_W'(count_q - CNT_W'(1));
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end else if (last) begin
						rsp_q.status <= ST_MISSING;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						idx_q <= nxt[IDX_W-1:0];
					end
				end
				S_SHIFT: begin
					// entry idx_q moves down one place this cycle
					if (last) begin
						count_q           <= count_q - CNT_W'(1);
						rsp_q.entry_count <= ECOUNT_W'(count_q - CNT_W'(1));
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else begin
						idx_q <= nxt[IDX_W-1:0];
					end
				end
				S_READ: begin
					rsp_q.read_value <= ITEM_W'(ram_rdata);
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A result strobe only ends a command that was in progress.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE))
		else $error("result strobe without a command in progress");

	// An accepted command always makes the block busy next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not start");

	// The list storage is written only while a command runs.
	a_write_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EXEC || state_q == S_SHIFT))
		else $error("entry write outside a command");

endmodule

`default_nettype wire
